@@ design/cbf_pkg.sv @@
// ----------------------------------------------------------------------------
// cbf_pkg
// Types and constants shared by the coprime basis factorizer modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int unsigned ValW  = 63;
  localparam int unsigned AddrW = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RESID = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_WL_A,
    OP_WL_TBL,
    OP_XY_LD,
    OP_DIV_XY,
    OP_DIV_YX,
    OP_X_Q,
    OP_Y_Q,
    OP_G_LD,
    OP_DIV_G,
    OP_G_STEP,
    OP_DIV_XG,
    OP_DIV_YG,
    OP_WL_X,
    OP_WL_Y,
    OP_WL_G,
    OP_A_WL,
    OP_NX_WL,
    OP_NX_A,
    OP_TBL_NX,
    OP_B_LD,
    OP_DIV_AB,
    OP_A_QC,
    OP_EX_WR,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic            command;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [5:0]      entry_index;
    logic [ValW-1:0] base_value;
    logic [5:0]      exponent;
    logic [6:0]      entry_count;
    logic            last;
  } res_t;

  typedef struct packed {
    dp_op_e           op;
    logic [AddrW-1:0] rd_a;
    logic [AddrW-1:0] rd_b;
    logic [AddrW-1:0] wr_a;
    logic [5:0]       res_index;
    logic [6:0]       res_count;
    status_e          res_status;
    logic             res_last;
    logic             res_full;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic rem_zero;
    logic x_gt1;
    logic y_gt1;
    logic gx_gt1;
    logic gy_nz;
    logic a_gt1;
    logic a_ne1;
    logic b_gt1;
    logic rd0_gt1;
  } dp_sts_t;

endpackage

@@ design/coprime_basis_factorizer.sv @@
// ----------------------------------------------------------------------------
// coprime_basis_factorizer
// Pairwise coprime basis: add values to it, or factorize values over it.
// ----------------------------------------------------------------------------
// A request (req_i: command, value) is taken on a clock edge with start high
// and busy low. Add refines the value against every basis entry; factorize
// divides it by each entry and reports exponents.
// Results appear on res_o for one cycle with res_valid_o high. Add and bad
// value give one; factorize gives one per entry, last marked (one if empty).
// The receiver cannot stall; results are never held back.
// Every division runs on one shared bit-serial divider, as does each gcd step.
// An add divides and takes gcd steps for every work-list pair of every entry,
// and factorize runs one division per exponent plus one for every entry.
// A bad value goes from S_IDLE to S_ONE, which issues its result through the
// result register. busy falls in the cycle that the final result is on res_o.
// Reset empties the basis; no memory clearing is needed.
// ----------------------------------------------------------------------------
module coprime_basis_factorizer #(
  parameter int unsigned MAX_BASIS  = 64,
  parameter int unsigned WORK_DEPTH = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cbf_pkg::req_t  req_i,
  output logic           res_valid_o,
  output cbf_pkg::res_t  res_o
);

  cbf_pkg::dp_cmd_t cmd;
  cbf_pkg::dp_sts_t sts;

  cbf_ctrl #(
    .MAX_BASIS  (MAX_BASIS),
    .WORK_DEPTH (WORK_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (req_i.command),
    .zero_i    (req_i.value == '0),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  cbf_datapath #(
    .MAX_BASIS  (MAX_BASIS),
    .WORK_DEPTH (WORK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !$past(busy) |-> !res_valid_o)
    else $error("result issued while idle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.entry_count <= 7'(MAX_BASIS))
    else $error("entry count beyond table depth");

endmodule

@@ design/cbf_div.sv @@
// ----------------------------------------------------------------------------
// cbf_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module cbf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbf_pkg::ValW-1:0]   dividend_i,
  input  logic [cbf_pkg::ValW-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [cbf_pkg::ValW-1:0]   quot_o,
  output logic [cbf_pkg::ValW-1:0]   rem_o
);

  logic [cbf_pkg::ValW-1:0] rem_q, quo_q, dsr_q;
  logic [5:0]               cnt_q;
  logic                     busy_q;
  logic [cbf_pkg::ValW:0]   shifted;
  logic [cbf_pkg::ValW+1:0] diff;
  logic                     ge;

  assign shifted = {rem_q, quo_q[cbf_pkg::ValW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = !diff[cbf_pkg::ValW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(cbf_pkg::ValW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[cbf_pkg::ValW-1:0] : shifted[cbf_pkg::ValW-1:0];
      quo_q <= {quo_q[cbf_pkg::ValW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/cbf_datapath.sv @@
// ----------------------------------------------------------------------------
// cbf_datapath
// Operand registers, table, scratch and exponent memories, shared divider.
// ----------------------------------------------------------------------------
module cbf_datapath #(
  parameter int unsigned MAX_BASIS  = 64,
  parameter int unsigned WORK_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbf_pkg::req_t     req_i,
  input  cbf_pkg::dp_cmd_t  cmd_i,
  output cbf_pkg::dp_sts_t  sts_o,
  output logic              res_valid_o,
  output cbf_pkg::res_t     res_o
);

  localparam int unsigned BAw = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int unsigned WAw = $clog2(WORK_DEPTH);

  logic [cbf_pkg::ValW-1:0] basis_mem [MAX_BASIS];
  logic [cbf_pkg::ValW-1:0] next_mem  [MAX_BASIS];
  logic [cbf_pkg::ValW-1:0] wl_mem    [WORK_DEPTH];
  logic [5:0]               expo_mem  [MAX_BASIS];

  logic [cbf_pkg::ValW-1:0] tbl_rd_q, nx_rd_q, wl_rd0_q, wl_rd1_q;
  logic [5:0]               ex_rd_q;
  logic [cbf_pkg::ValW-1:0] a_q, b_q, x_q, y_q, gx_q, gy_q;
  logic [5:0]               c_q;
  logic                     res_valid_q;
  cbf_pkg::res_t            res_q;

  logic                     div_start, div_busy;
  logic [cbf_pkg::ValW-1:0] div_n, div_d, quot, rem;

  logic [BAw-1:0] ba_rd, ba_wr;
  logic [WAw-1:0] wa_rd0, wa_rd1, wa_wr;

  assign ba_rd  = cmd_i.rd_a[BAw-1:0];
  assign ba_wr  = cmd_i.wr_a[BAw-1:0];
  assign wa_rd0 = cmd_i.rd_a[WAw-1:0];
  assign wa_rd1 = cmd_i.rd_b[WAw-1:0];
  assign wa_wr  = cmd_i.wr_a[WAw-1:0];

  always_comb begin
    div_start = 1'b1;
    div_n     = x_q;
    div_d     = y_q;
    case (cmd_i.op)
      cbf_pkg::OP_DIV_XY: begin
        div_n = x_q;
        div_d = y_q;
      end
      cbf_pkg::OP_DIV_YX: begin
        div_n = y_q;
        div_d = x_q;
      end
      cbf_pkg::OP_DIV_G: begin
        div_n = gx_q;
        div_d = gy_q;
      end
      cbf_pkg::OP_DIV_XG: begin
        div_n = x_q;
        div_d = gx_q;
      end
      cbf_pkg::OP_DIV_YG: begin
        div_n = y_q;
        div_d = gx_q;
      end
      cbf_pkg::OP_DIV_AB: begin
        div_n = a_q;
        div_d = b_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  cbf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= basis_mem[ba_rd];
    nx_rd_q  <= next_mem[ba_rd];
    ex_rd_q  <= expo_mem[ba_rd];
    wl_rd0_q <= wl_mem[wa_rd0];
    wl_rd1_q <= wl_mem[wa_rd1];
    case (cmd_i.op)
      cbf_pkg::OP_WL_A:   wl_mem[wa_wr]    <= a_q;
      cbf_pkg::OP_WL_TBL: wl_mem[wa_wr]    <= tbl_rd_q;
      cbf_pkg::OP_WL_X:   wl_mem[wa_wr]    <= x_q;
      cbf_pkg::OP_WL_Y:   wl_mem[wa_wr]    <= y_q;
      cbf_pkg::OP_WL_G:   wl_mem[wa_wr]    <= gx_q;
      cbf_pkg::OP_NX_WL:  next_mem[ba_wr]  <= wl_rd0_q;
      cbf_pkg::OP_NX_A:   next_mem[ba_wr]  <= a_q;
      cbf_pkg::OP_TBL_NX: basis_mem[ba_wr] <= nx_rd_q;
      cbf_pkg::OP_EX_WR:  expo_mem[ba_wr]  <= c_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cbf_pkg::OP_CAPTURE: a_q <= req_i.value;
      cbf_pkg::OP_XY_LD: begin
        x_q <= wl_rd0_q;
        y_q <= wl_rd1_q;
      end
      cbf_pkg::OP_X_Q: x_q <= quot;
      cbf_pkg::OP_Y_Q: y_q <= quot;
      cbf_pkg::OP_G_LD: begin
        gx_q <= x_q;
        gy_q <= y_q;
      end
      cbf_pkg::OP_G_STEP: begin
        gx_q <= gy_q;
        gy_q <= rem;
      end
      cbf_pkg::OP_A_WL: a_q <= wl_rd0_q;
      cbf_pkg::OP_B_LD: begin
        b_q <= tbl_rd_q;
        c_q <= '0;
      end
      cbf_pkg::OP_A_QC: begin
        a_q <= quot;
        c_q <= c_q + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.op == cbf_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cbf_pkg::OP_EMIT) begin
      res_q.status      <= cmd_i.res_status;
      res_q.entry_index <= cmd_i.res_index;
      res_q.base_value  <= cmd_i.res_full ? tbl_rd_q : '0;
      res_q.exponent    <= cmd_i.res_full ? ex_rd_q : '0;
      res_q.entry_count <= cmd_i.res_count;
      res_q.last        <= cmd_i.res_last;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.rem_zero = (rem == '0);
  assign sts_o.x_gt1    = (x_q > 63'd1);
  assign sts_o.y_gt1    = (y_q > 63'd1);
  assign sts_o.gx_gt1   = (gx_q > 63'd1);
  assign sts_o.gy_nz    = (gy_q != '0);
  assign sts_o.a_gt1    = (a_q > 63'd1);
  assign sts_o.a_ne1    = (a_q != 63'd1);
  assign sts_o.b_gt1    = (b_q > 63'd1);
  assign sts_o.rd0_gt1  = (wl_rd0_q > 63'd1);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ design/cbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbf_ctrl
// Sequencer for add and factorize requests; owns the entry and work-list counters.
// ----------------------------------------------------------------------------
module cbf_ctrl #(
  parameter int unsigned MAX_BASIS  = 64,
  parameter int unsigned WORK_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              command_i,
  input  logic              zero_i,
  input  cbf_pkg::dp_sts_t  sts_i,
  output cbf_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);

  localparam int unsigned CntW = $clog2(MAX_BASIS + 1);
  localparam int unsigned SzW  = $clog2(WORK_DEPTH + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ONE   = 5'd1;
  localparam logic [4:0] S_E     = 5'd2;
  localparam logic [4:0] S_E2    = 5'd3;
  localparam logic [4:0] S_I     = 5'd4;
  localparam logic [4:0] S_J     = 5'd5;
  localparam logic [4:0] S_J2    = 5'd6;
  localparam logic [4:0] S_W     = 5'd7;
  localparam logic [4:0] S_W1    = 5'd8;
  localparam logic [4:0] S_W2    = 5'd9;
  localparam logic [4:0] S_G     = 5'd10;
  localparam logic [4:0] S_G1    = 5'd11;
  localparam logic [4:0] S_G2    = 5'd12;
  localparam logic [4:0] S_G3    = 5'd13;
  localparam logic [4:0] S_G4    = 5'd14;
  localparam logic [4:0] S_G5    = 5'd15;
  localparam logic [4:0] S_G6    = 5'd16;
  localparam logic [4:0] S_WB0   = 5'd17;
  localparam logic [4:0] S_WB1   = 5'd18;
  localparam logic [4:0] S_A0    = 5'd19;
  localparam logic [4:0] S_A2    = 5'd20;
  localparam logic [4:0] S_A3    = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;
  localparam logic [4:0] S_C     = 5'd23;
  localparam logic [4:0] S_C2    = 5'd24;
  localparam logic [4:0] S_F     = 5'd25;
  localparam logic [4:0] S_F1    = 5'd26;
  localparam logic [4:0] S_F2    = 5'd27;
  localparam logic [4:0] S_F3    = 5'd28;
  localparam logic [4:0] S_F4    = 5'd29;
  localparam logic [4:0] S_O     = 5'd30;
  localparam logic [4:0] S_O1    = 5'd31;

  logic [4:0]            state_q, state_d;
  logic [CntW-1:0]       e_q, e_d, nc_q, nc_d;
  logic [SzW-1:0]        i_q, i_d, j_q, j_d, size_q, size_d;
  logic [6:0]            cnt_q, cnt_d;
  cbf_pkg::status_e      st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_q     <= '0;
      nc_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      size_q  <= '0;
      cnt_q   <= '0;
      st_q    <= cbf_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      nc_q    <= nc_d;
      i_q     <= i_d;
      j_q     <= j_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    e_d     = e_q;
    nc_d    = nc_q;
    i_d     = i_q;
    j_d     = j_q;
    size_d  = size_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    cmd_o            = '0;
    cmd_o.op         = cbf_pkg::OP_NONE;
    cmd_o.res_status = st_q;
    cmd_o.res_count  = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = cbf_pkg::OP_CAPTURE;
          e_d      = '0;
          nc_d     = '0;
          if (zero_i) begin
            st_d    = cbf_pkg::ST_BAD;
            state_d = S_ONE;
          end else if (!command_i) begin
            state_d = S_E;
          end else begin
            state_d = S_F;
          end
        end
      end
      S_ONE: begin
        cmd_o.op       = cbf_pkg::OP_EMIT;
        cmd_o.res_last = 1'b1;
        state_d        = S_IDLE;
      end
      S_E: begin
        if (7'(e_q) < cnt_q) begin
          cmd_o.rd_a = 8'(e_q);
          cmd_o.op   = cbf_pkg::OP_WL_A;
          cmd_o.wr_a = 8'd0;
          size_d     = SzW'(2);
          i_d        = SzW'(1);
          state_d    = S_E2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_E2: begin
        cmd_o.op   = cbf_pkg::OP_WL_TBL;
        cmd_o.wr_a = 8'd1;
        state_d    = S_I;
      end
      S_I: begin
        if (i_q < size_q) begin
          j_d     = '0;
          state_d = S_J;
        end else begin
          state_d = S_A0;
        end
      end
      S_J: begin
        if (j_q < i_q) begin
          cmd_o.rd_a = 8'(j_q);
          cmd_o.rd_b = 8'(i_q);
          state_d    = S_J2;
        end else begin
          i_d     = i_q + SzW'(1);
          state_d = S_I;
        end
      end
      S_J2: begin
        cmd_o.op = cbf_pkg::OP_XY_LD;
        state_d  = S_W;
      end
      S_W: begin
        if (sts_i.x_gt1 && sts_i.y_gt1) begin
          cmd_o.op = cbf_pkg::OP_DIV_XY;
          state_d  = S_W1;
        end else begin
          state_d = S_WB0;
        end
      end
      S_W1: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.op = cbf_pkg::OP_X_Q;
            state_d  = S_W;
          end else begin
            cmd_o.op = cbf_pkg::OP_DIV_YX;
            state_d  = S_W2;
          end
        end
      end
      S_W2: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.op = cbf_pkg::OP_Y_Q;
            state_d  = S_W;
          end else begin
            cmd_o.op = cbf_pkg::OP_G_LD;
            state_d  = S_G;
          end
        end
      end
      S_G: begin
        if (sts_i.gy_nz) begin
          cmd_o.op = cbf_pkg::OP_DIV_G;
          state_d  = S_G1;
        end else begin
          state_d = S_G2;
        end
      end
      S_G1: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = cbf_pkg::OP_G_STEP;
          state_d  = S_G;
        end
      end
      S_G2: begin
        if (!sts_i.gx_gt1) begin
          state_d = S_WB0;
        end else if (size_q >= SzW'(WORK_DEPTH)) begin
          st_d    = cbf_pkg::ST_FULL;
          state_d = S_ONE;
        end else begin
          cmd_o.op = cbf_pkg::OP_DIV_XG;
          state_d  = S_G3;
        end
      end
      S_G3: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = cbf_pkg::OP_X_Q;
          state_d  = S_G4;
        end
      end
      S_G4: begin
        cmd_o.op = cbf_pkg::OP_DIV_YG;
        state_d  = S_G5;
      end
      S_G5: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = cbf_pkg::OP_Y_Q;
          state_d  = S_G6;
        end
      end
      S_G6: begin
        cmd_o.op   = cbf_pkg::OP_WL_G;
        cmd_o.wr_a = 8'(size_q);
        size_d     = size_q + SzW'(1);
        state_d    = S_WB0;
      end
      S_WB0: begin
        cmd_o.op   = cbf_pkg::OP_WL_X;
        cmd_o.wr_a = 8'(j_q);
        state_d    = S_WB1;
      end
      S_WB1: begin
        cmd_o.op   = cbf_pkg::OP_WL_Y;
        cmd_o.wr_a = 8'(i_q);
        j_d        = j_q + SzW'(1);
        state_d    = S_J;
      end
      S_A0: begin
        cmd_o.rd_a = 8'd0;
        j_d        = SzW'(1);
        state_d    = S_A2;
      end
      S_A2: begin
        if (j_q == SzW'(1)) begin
          cmd_o.op = cbf_pkg::OP_A_WL;
        end
        if (j_q < size_q) begin
          cmd_o.rd_a = 8'(j_q);
          state_d    = S_A3;
        end else begin
          e_d     = e_q + CntW'(1);
          state_d = S_E;
        end
      end
      S_A3: begin
        j_d     = j_q + SzW'(1);
        state_d = S_A2;
        if (sts_i.rd0_gt1) begin
          if (nc_q >= CntW'(MAX_BASIS)) begin
            st_d    = cbf_pkg::ST_FULL;
            state_d = S_ONE;
          end else begin
            cmd_o.op   = cbf_pkg::OP_NX_WL;
            cmd_o.wr_a = 8'(nc_q);
            nc_d       = nc_q + CntW'(1);
          end
        end
      end
      S_FIN: begin
        e_d     = '0;
        state_d = S_C;
        if (sts_i.a_gt1) begin
          if (nc_q >= CntW'(MAX_BASIS)) begin
            st_d    = cbf_pkg::ST_FULL;
            state_d = S_ONE;
          end else begin
            cmd_o.op   = cbf_pkg::OP_NX_A;
            cmd_o.wr_a = 8'(nc_q);
            nc_d       = nc_q + CntW'(1);
          end
        end
      end
      S_C: begin
        if (e_q < nc_q) begin
          cmd_o.rd_a = 8'(e_q);
          state_d    = S_C2;
        end else begin
          cnt_d   = 7'(nc_q);
          st_d    = cbf_pkg::ST_OK;
          state_d = S_ONE;
        end
      end
      S_C2: begin
        cmd_o.op   = cbf_pkg::OP_TBL_NX;
        cmd_o.wr_a = 8'(e_q);
        e_d        = e_q + CntW'(1);
        state_d    = S_C;
      end
      S_F: begin
        if (7'(e_q) < cnt_q) begin
          cmd_o.rd_a = 8'(e_q);
          state_d    = S_F1;
        end else begin
          st_d = sts_i.a_ne1 ? cbf_pkg::ST_RESID : cbf_pkg::ST_OK;
          e_d  = '0;
          state_d = (cnt_q == '0) ? S_ONE : S_O;
        end
      end
      S_F1: begin
        cmd_o.op = cbf_pkg::OP_B_LD;
        state_d  = S_F2;
      end
      S_F2: begin
        if (sts_i.b_gt1) begin
          cmd_o.op = cbf_pkg::OP_DIV_AB;
          state_d  = S_F3;
        end else begin
          state_d = S_F4;
        end
      end
      S_F3: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.op = cbf_pkg::OP_A_QC;
            state_d  = S_F2;
          end else begin
            state_d = S_F4;
          end
        end
      end
      S_F4: begin
        cmd_o.op   = cbf_pkg::OP_EX_WR;
        cmd_o.wr_a = 8'(e_q);
        e_d        = e_q + CntW'(1);
        state_d    = S_F;
      end
      S_O: begin
        cmd_o.rd_a = 8'(e_q);
        state_d    = S_O1;
      end
      S_O1: begin
        cmd_o.op        = cbf_pkg::OP_EMIT;
        cmd_o.res_full  = 1'b1;
        cmd_o.res_index = 6'(e_q);
        cmd_o.res_last  = ((7'(e_q) + 7'd1) == cnt_q);
        e_d             = e_q + CntW'(1);
        state_d         = cmd_o.res_last ? S_IDLE : S_O;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
